// File: sv/csmm_pkg.sv
`default_nettype none
package csmm_pkg;

    localparam int NUM_CH    = 3;
    localparam int PIX_W     = 8;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_ZERO = '0;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_MEASURE = 2'd1;
    localparam logic [1:0] FUNC_APPLY   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FULL,
        RES_DIV
    } t_res;

    typedef struct packed {
        logic stat_clr;
        logic stat_upd;
        logic load_px;
        logic prep;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage
`default_nettype wire

// File: sv/contrast_stretch_minmax.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_func, i_red_in, i_green_in, i_blue_in
// result    out        o_valid / i_ready    o_red_out, o_green_out, o_blue_out
// config    in         i_cfg_we             i_cfg_wdata (gray mode)
//
// Clear and measure requests are taken while idle; o_ready stays high.
// Apply keeps o_ready low through operand prep, the bit-serial dividers
// (three in parallel, one per channel), then the output register load.
// The result shows once the output register is loaded after the dividers finish.
// Apply holds in its last step while the previous result is still unclaimed.
// Reset (i_rst_n low, synchronous) sets min to 255, max to 0, gray mode off.
module contrast_stretch_minmax (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_red_out,
    output      logic [7:0]  o_green_out,
    output      logic [7:0]  o_blue_out
);

    csmm_pkg::t_cmd w_cmd;

    csmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    csmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out)
    );

endmodule
`default_nettype wire

// File: sv/csmm_ctrl.sv
`default_nettype none
module csmm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_func,
    output      logic             o_ready,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      csmm_pkg::t_cmd   o_cmd
);

    csmm_pkg::t_state                 r_state, n_state;
    logic [csmm_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= csmm_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            csmm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        csmm_pkg::FUNC_CLEAR:   o_cmd.stat_clr = 1'b1;
                        csmm_pkg::FUNC_MEASURE: o_cmd.stat_upd = 1'b1;
                        csmm_pkg::FUNC_APPLY: begin
                            o_cmd.load_px = 1'b1;
                            n_state       = csmm_pkg::ST_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            csmm_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = csmm_pkg::ST_DIV;
            end
            csmm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == csmm_pkg::CNT_W'(csmm_pkg::DIV_STEPS - 1)) begin
                    n_state = csmm_pkg::ST_DONE;
                end
            end
            csmm_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_vld || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = csmm_pkg::ST_IDLE;
                end
            end
            default: n_state = csmm_pkg::ST_IDLE;
        endcase
        n_out_vld = (r_out_vld && !i_ready) || o_cmd.out_load;
    end

    assign o_ready = (r_state == csmm_pkg::ST_IDLE);
    assign o_valid = r_out_vld;

endmodule
`default_nettype wire

// File: sv/csmm_dp.sv
`default_nettype none
module csmm_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire csmm_pkg::t_cmd              i_cmd,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_wdata,
    input  wire logic [csmm_pkg::PIX_W-1:0]  i_red,
    input  wire logic [csmm_pkg::PIX_W-1:0]  i_green,
    input  wire logic [csmm_pkg::PIX_W-1:0]  i_blue,
    output      logic [csmm_pkg::PIX_W-1:0]  o_red,
    output      logic [csmm_pkg::PIX_W-1:0]  o_green,
    output      logic [csmm_pkg::PIX_W-1:0]  o_blue
);

    localparam int W = csmm_pkg::PIX_W;

    logic          r_gray;
    logic [W-1:0]  w_px  [csmm_pkg::NUM_CH];
    logic [W-1:0]  r_out [csmm_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= 1'b0;
        end else if (i_cfg_we) begin
            r_gray <= i_cfg_wdata;
        end
    end

    assign w_px[0] = i_red;
    assign w_px[1] = i_green;
    assign w_px[2] = i_blue;

    for (genvar g = 0; g < csmm_pkg::NUM_CH; g++) begin : g_ch
        logic [W-1:0]                  r_min, r_max, r_px, r_span, r_rem, r_quo;
        csmm_pkg::t_res                r_sel, w_sel;
        logic [W-1:0]                  w_diff;
        logic [csmm_pkg::NUM_W-1:0]    w_num;
        logic [W:0]                    w_trial;
        logic                          w_ge;
        logic                          w_used;

        assign w_used = (g == 0) || !r_gray;

        // running statistics
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.stat_clr) begin
                r_min <= csmm_pkg::PIX_MAX;
                r_max <= csmm_pkg::PIX_ZERO;
            end else if (i_cmd.stat_upd && w_used) begin
                if (w_px[g] < r_min) begin
                    r_min <= w_px[g];
                end
                if (w_px[g] > r_max) begin
                    r_max <= w_px[g];
                end
            end
        end

        // 255 * (p - min) as (d << 8) - d
        assign w_diff = r_px - r_min;
        assign w_num  = {w_diff, csmm_pkg::PIX_ZERO} - {csmm_pkg::PIX_ZERO, w_diff};

        always_comb begin
            if (!w_used || r_max <= r_min || r_px <= r_min) begin
                w_sel = csmm_pkg::RES_ZERO;
            end else if (r_px >= r_max) begin
                w_sel = csmm_pkg::RES_FULL;
            end else begin
                w_sel = csmm_pkg::RES_DIV;
            end
        end

        // restoring divider, one quotient bit a cycle; quotient fits in W bits
        assign w_trial = {r_rem, r_quo[W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_span});

        always_ff @(posedge i_clk) begin
            if (i_cmd.load_px) begin
                r_px <= w_px[g];
            end
            if (i_cmd.prep) begin
                r_span <= r_max - r_min;
                r_rem  <= w_num[csmm_pkg::NUM_W-1:W];
                r_quo  <= w_num[W-1:0];
                r_sel  <= w_sel;
            end else if (i_cmd.div_step) begin
                r_rem  <= w_ge ? W'(w_trial - {1'b0, r_span}) : w_trial[W-1:0];
                r_quo  <= {r_quo[W-2:0], w_ge};
            end
            if (i_cmd.out_load) begin
                case (r_sel)
                    csmm_pkg::RES_FULL: r_out[g] <= csmm_pkg::PIX_MAX;
                    csmm_pkg::RES_DIV:  r_out[g] <= r_quo;
                    default:            r_out[g] <= csmm_pkg::PIX_ZERO;
                endcase
            end
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule
`default_nettype wire

// File: sv/csmm_chk.sv
`default_nettype none
module csmm_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [7:0]  o_red_out,
    input  wire logic [7:0]  o_green_out,
    input  wire logic [7:0]  o_blue_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=>
            $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out))
        else $error("stalled result changed");

    a_stat_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func != csmm_pkg::FUNC_APPLY |=> o_ready)
        else $error("clear or measure request stalled the input");

    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func == csmm_pkg::FUNC_APPLY |=> !o_ready ##1 !o_ready)
        else $error("apply request did not occupy the divider");

endmodule

bind contrast_stretch_minmax csmm_chk u_csmm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_func      (i_func),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
`default_nettype wire
